[rtl/modular_exponentiation_core_assert.svh]
// Assertion macros used by the checker file.
`ifndef MODULAR_EXPONENTIATION_CORE_ASSERT_SVH
`define MODULAR_EXPONENTIATION_CORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define MEXP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mexp_pkg.sv]
`timescale 1ns / 1ps

package mexp_pkg;

  // Configuration register map
  localparam int unsigned CfgAddrW = 1;
  localparam logic [CfgAddrW-1:0] CFG_MODULUS  = 1'b0;
  localparam logic [CfgAddrW-1:0] CFG_EXPONENT = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_BIT,
    S_MULACC,
    S_SQUARE
  } mexp_state_e;

  // Handshake between the sequencer and the serial multiplier
  typedef struct packed {
    logic start;
  } mexp_mul_req_t;

  typedef struct packed {
    logic done;
  } mexp_mul_rsp_t;

endpackage

[rtl/modular_exponentiation_core.sv]
`timescale 1ns / 1ps
// Modular exponentiation core: power_mod = base ^ exponent mod modulus.
// Configuration: write modulus (index 0) and exponent (index 1) on the
// cfg_valid_i / cfg_addr_i / cfg_data_i channel; cfg_ready_o is always high.
// Write configuration only while busy is low and no result is pending.
// Input: drive base_i with start high; the item is taken when busy is low.
// Output: result_valid_o pulses for one cycle with power_mod_o; the receiver
// cannot stall, so the result must be captured in that cycle.
// The exponent is scanned LSB first. Each step runs a bit-serial modular
// multiplier; the base is first reduced by one such pass when the modulus is
// nonzero. A zero exponent bit costs a square, a one bit a multiply into the
// accumulator and then a square, and no square follows the top bit.
// An exponent of zero returns 1 in the cycle after the item is taken.
// A modulus of zero gives results modulo 2^WIDTH.
// One item is worked on at a time; busy stays high until the result pulse.
// Reset clears the sequencer, any pending result, and sets modulus to 1 and
// exponent to 0.

module modular_exponentiation_core
  import mexp_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [WIDTH-1:0]    cfg_data_i,
  input  logic                start,
  output logic                busy,
  input  logic [WIDTH-1:0]    base_i,
  output logic                result_valid_o,
  output logic [WIDTH-1:0]    power_mod_o
);

  localparam logic [WIDTH-1:0] OneW = WIDTH'(1);

  mexp_state_e      state_q, state_d;
  logic [WIDTH-1:0] modulus_q, modulus_d;
  logic [WIDTH-1:0] exponent_q, exponent_d;
  logic [WIDTH-1:0] sq_q, sq_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] exp_q, exp_d;
  logic [WIDTH-1:0] res_q, res_d;
  logic             res_valid_q, res_valid_d;

  mexp_mul_req_t    mul_req;
  mexp_mul_rsp_t    mul_rsp;
  logic [WIDTH-1:0] mul_x;
  logic [WIDTH-1:0] mul_y;
  logic [WIDTH-1:0] mul_prod;
  logic [WIDTH-1:0] exp_shr;

  assign cfg_ready_o = 1'b1;
  assign exp_shr     = exp_q >> 1;

  // Apply configuration writes
  always_comb begin
    modulus_d  = modulus_q;
    exponent_d = exponent_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        CFG_MODULUS:  modulus_d  = cfg_data_i;
        CFG_EXPONENT: exponent_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequence reduction, multiplications and squarings
  always_comb begin
    state_d     = state_q;
    sq_d        = sq_q;
    acc_d       = acc_q;
    exp_d       = exp_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    mul_req     = '0;
    mul_x       = sq_q;
    mul_y       = sq_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          sq_d  = base_i;
          acc_d = OneW;
          exp_d = exponent_q;
          if (exponent_q == '0) begin
            res_d       = OneW;
            res_valid_d = 1'b1;
          end else if (modulus_q == '0) begin
            state_d = S_BIT;
          end else begin
            // base mod n as (1 mod n) * base
            mul_req.start = 1'b1;
            mul_x         = (modulus_q == OneW) ? '0 : OneW;
            mul_y         = base_i;
            state_d       = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (mul_rsp.done) begin
          sq_d    = mul_prod;
          state_d = S_BIT;
        end
      end
      S_BIT: begin
        mul_req.start = 1'b1;
        if (exp_q[0]) begin
          mul_y   = acc_q;
          state_d = S_MULACC;
        end else begin
          exp_d   = exp_shr;
          state_d = S_SQUARE;
        end
      end
      S_MULACC: begin
        if (mul_rsp.done) begin
          acc_d = mul_prod;
          exp_d = exp_shr;
          if (exp_shr == '0) begin
            res_d       = mul_prod;
            res_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else begin
            mul_req.start = 1'b1;
            state_d       = S_SQUARE;
          end
        end
      end
      S_SQUARE: begin
        if (mul_rsp.done) begin
          sq_d    = mul_prod;
          state_d = S_BIT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  mexp_mulmod #(
    .WIDTH(WIDTH)
  ) u_mulmod (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .x_i   (mul_x),
    .y_i   (mul_y),
    .n_i   (modulus_q),
    .rsp_o (mul_rsp),
    .prod_o(mul_prod)
  );

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      modulus_q   <= OneW;
      exponent_q  <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      modulus_q   <= modulus_d;
      exponent_q  <= exponent_d;
    end
  end

  // Working values
  always_ff @(posedge clk_i) begin
    sq_q  <= sq_d;
    acc_q <= acc_d;
    exp_q <= exp_d;
    res_q <= res_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign power_mod_o    = res_q;

endmodule

[rtl/mexp_mulmod.sv]
`timescale 1ns / 1ps

module mexp_mulmod
  import mexp_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mexp_mul_req_t        req_i,
  input  logic [WIDTH-1:0]     x_i,
  input  logic [WIDTH-1:0]     y_i,
  input  logic [WIDTH-1:0]     n_i,
  output mexp_mul_rsp_t        rsp_o,
  output logic [WIDTH-1:0]     prod_o
);

  localparam int unsigned CntW = $clog2(WIDTH);

  logic [WIDTH-1:0] x_q, x_d;
  logic [WIDTH-1:0] y_q, y_d;
  logic [WIDTH-1:0] n_q, n_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;

  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] n1;
  logic [WIDTH+1:0] n2;
  logic [WIDTH+1:0] red;

  // One multiplier bit per cycle, MSB first: acc = 2*acc + bit*x, reduced
  always_comb begin
    sum = {1'b0, acc_q, 1'b0} + {2'b00, (y_q[WIDTH-1] ? x_q : '0)};
    n1  = {2'b00, n_q};
    n2  = {1'b0, n_q, 1'b0};
    if (n_q == '0) begin
      red = sum;
    end else if (sum >= n2) begin
      red = sum - n2;
    end else if (sum >= n1) begin
      red = sum - n1;
    end else begin
      red = sum;
    end
  end

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    n_d    = n_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      x_d   = x_i;
      y_d   = y_i;
      n_d   = n_i;
      acc_d = '0;
      cnt_d = CntW'(WIDTH - 1);
      run_d = 1'b1;
    end else if (run_q) begin
      acc_d = red[WIDTH-1:0];
      y_d   = {y_q[WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands and partial result
  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    n_q   <= n_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign prod_o     = acc_q;

endmodule

[rtl/mexp_checker.sv]
`timescale 1ns / 1ps
`include "modular_exponentiation_core_assert.svh"

module mexp_checker
  import mexp_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [CfgAddrW-1:0] cfg_addr_i,
  input logic [WIDTH-1:0]    cfg_data_i,
  input logic                start,
  input logic                busy,
  input logic [WIDTH-1:0]    base_i,
  input logic                result_valid_o,
  input logic [WIDTH-1:0]    power_mod_o
);

  // A result is shown only once the core has gone idle
  `MEXP_ASSERT_NOW(a_result_when_idle, result_valid_o, !busy, "result while busy")

  // An accepted item either starts work or finishes at once
  `MEXP_ASSERT_NEXT(a_accept_progress, start && !busy, busy || result_valid_o, "item dropped")

  // Busy drops only together with a result
  `MEXP_ASSERT_NOW(a_busy_fall_result, $fell(busy), result_valid_o, "busy fell without result")

endmodule

bind modular_exponentiation_core mexp_checker #(.WIDTH(WIDTH)) u_mexp_checker (.*);
